// ===== src/v2sc_pkg.sv =====
package v2sc_pkg;

    // Command framing
    localparam int unsigned CmdLen  = 17;
    localparam logic [4:0]  LastIdx = 5'(CmdLen - 1);

    // ASCII codes
    localparam logic [7:0] CharA    = 8'h41;
    localparam logic [7:0] CharR    = 8'h52;
    localparam logic [7:0] CharP    = 8'h50;
    localparam logic [7:0] CharS    = 8'h53;
    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharOne  = 8'h31;
    localparam logic [7:0] CharTwo  = 8'h32;
    localparam logic [7:0] CharErr  = 8'h00;

    // Range selection thresholds in uV, already adjusted for round-half-up carry
    localparam logic [30:0] ErrLimit = 31'd999_999_500;
    localparam logic [30:0] Rng3Min  = 31'd99_999_950;
    localparam logic [30:0] Rng2Min  = 31'd9_999_995;
    localparam logic [30:0] Rng1Min  = 31'd1_000_000;

    // Range codes
    localparam logic [1:0] Rng0 = 2'd0;
    localparam logic [1:0] Rng1 = 2'd1;
    localparam logic [1:0] Rng2 = 2'd2;
    localparam logic [1:0] Rng3 = 2'd3;

    // Reciprocals for exact division of a 32-bit value by 10, 100, 1000
    localparam logic [31:0] RecipDiv10   = 32'hCCCC_CCCD; // >> 35
    localparam logic [31:0] RecipDiv100  = 32'h51EB_851F; // >> 37
    localparam logic [31:0] RecipDiv1000 = 32'h1062_4DD3; // >> 38

    // Reciprocal for exact division of a 20-bit value below 4194304 by 10 (>> 23)
    localparam logic [19:0] RecipDigit = 20'd838_861;

    // Item in the digit extraction part of the pipeline
    typedef struct packed {
        logic             neg;
        logic             err;
        logic [1:0]       rng;
        logic [19:0]      q;
        logic [19:0]      quot;
        logic [5:0][3:0]  digits;
    } t_dig_item;

endpackage

// ===== src/voltage_to_source_command.sv =====
// Voltage set-command encoder. A transaction is accepted on a rising edge with start high and
// busy low; it yields either the 17-byte ASCII command, one byte per cycle on o_char_code with
// o_valid high for exactly one cycle each and o_last_char on the final 'S', or a single error
// byte (0, with o_last_char and o_out_of_range) when the rounded magnitude reaches 1000 V. The
// first byte passes through the front, digit, serializer and output registers, and the bytes of
// one command follow in consecutive cycles. The one-byte output serializer sets the rate: a
// command holds it for all of its bytes, one error result passes per cycle. Nine pipeline
// stages sit in front of it, so start may be pulsed while earlier transactions are in flight;
// busy rises only when the serializer backs up the pipeline. The result port cannot be stalled.
module voltage_to_source_command (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_voltage_uv,
    output logic               o_valid,
    output logic [7:0]         o_char_code,
    output logic               o_last_char,
    output logic               o_out_of_range
);
    import v2sc_pkg::*;

    localparam int unsigned NumDig = 6;

    // floor(x / 10) for x below 4194304
    function automatic logic [19:0] div10(input logic [19:0] x);
        logic [39:0] p;
        p = x * RecipDigit;
        return {3'b000, p[39:23]};
    endfunction

    // Move the low decimal digit of q into the given slot and divide q by ten
    function automatic t_dig_item peel_digit(input t_dig_item x, input logic [2:0] slot);
        t_dig_item y;
        y              = x;
        y.digits[slot] = 4'(x.q - {x.quot[16:0], 3'b000} - {x.quot[18:0], 1'b0});
        y.q            = x.quot;
        y.quot         = div10(x.quot);
        return y;
    endfunction

    // Front stages
    logic        r1_valid, r2_valid, r3_valid;
    logic [30:0] r1_mag;
    logic        r1_neg;
    logic [30:0] r2_sum;
    logic [1:0]  r2_rng;
    logic        r2_err, r2_neg;
    logic [28:0] r3_ph;
    logic [19:0] r3_sum_lo;
    logic [1:0]  r3_rng;
    logic        r3_err, r3_neg;

    // Digit stages
    t_dig_item   r_dp [NumDig];
    logic [NumDig-1:0] r_dvalid;

    // Serializer and output registers
    t_dig_item   r_ser;
    logic        r_ser_valid;
    logic [4:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;
    logic        r_out_err;

    // Combinational signals
    logic              ser_done, ser_free;
    logic [NumDig-1:0] d_ready;
    logic              rdy1, rdy2, rdy3;
    logic [30:0]       n1_mag;
    logic [1:0]        n2_rng;
    logic [30:0]       n2_half;
    logic [31:0]       recip;
    logic [63:0]       prod;
    logic [19:0]       n_q0;
    logic [7:0]        n_char;

    // Ready chain from the serializer back to the input
    always_comb begin
        ser_done = r_ser_valid && (r_ser.err || (r_idx == LastIdx));
        ser_free = !r_ser_valid || ser_done;
        d_ready[NumDig-1] = !r_dvalid[NumDig-1] || ser_free;
        for (int j = NumDig - 2; j >= 0; j--) begin
            d_ready[j] = !r_dvalid[j] || d_ready[j+1];
        end
        rdy3 = !r3_valid || d_ready[0];
        rdy2 = !r2_valid || rdy3;
        rdy1 = !r1_valid || rdy2;
    end

    assign busy = !rdy1;

    // Stage 1: magnitude
    assign n1_mag = i_voltage_uv[30] ? (31'd0 - i_voltage_uv) : i_voltage_uv;

    // Stage 2: range and rounding offset
    always_comb begin
        if (r1_mag >= Rng3Min) begin
            n2_rng  = Rng3;
            n2_half = 31'd500;
        end else if (r1_mag >= Rng2Min) begin
            n2_rng  = Rng2;
            n2_half = 31'd50;
        end else if (r1_mag >= Rng1Min) begin
            n2_rng  = Rng1;
            n2_half = 31'd5;
        end else begin
            n2_rng  = Rng0;
            n2_half = 31'd0;
        end
    end

    // Stage 3: reciprocal multiply
    always_comb begin
        case (r2_rng)
            Rng1:    recip = RecipDiv10;
            Rng2:    recip = RecipDiv100;
            Rng3:    recip = RecipDiv1000;
            default: recip = RecipDiv10;
        endcase
        prod = {1'b0, r2_sum} * recip;
    end

    // Digit stage 0 input: scaled six-digit value
    always_comb begin
        case (r3_rng)
            Rng0:    n_q0 = r3_sum_lo;
            Rng1:    n_q0 = r3_ph[19:0];
            Rng2:    n_q0 = r3_ph[21:2];
            Rng3:    n_q0 = r3_ph[22:3];
            default: n_q0 = r3_sum_lo;
        endcase
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_dvalid    <= '0;
            r_ser_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= start;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
            if (d_ready[0]) r_dvalid[0] <= r3_valid;
            for (int j = 1; j < NumDig; j++) begin
                if (d_ready[j]) r_dvalid[j] <= r_dvalid[j-1];
            end
            if (ser_free) begin
                r_ser_valid <= r_dvalid[NumDig-1];
                r_idx       <= '0;
            end else begin
                r_idx       <= r_idx + 5'd1;
            end
            r_out_valid <= r_ser_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_mag <= n1_mag;
            r1_neg <= i_voltage_uv[30];
        end
        if (rdy2) begin
            r2_sum <= r1_mag + n2_half;
            r2_rng <= n2_rng;
            r2_err <= (r1_mag >= ErrLimit);
            r2_neg <= r1_neg;
        end
        if (rdy3) begin
            r3_ph     <= prod[63:35];
            r3_sum_lo <= r2_sum[19:0];
            r3_rng    <= r2_rng;
            r3_err    <= r2_err;
            r3_neg    <= r2_neg;
        end
        if (d_ready[0]) begin
            r_dp[0].neg    <= r3_neg;
            r_dp[0].err    <= r3_err;
            r_dp[0].rng    <= r3_rng;
            r_dp[0].q      <= n_q0;
            r_dp[0].quot   <= div10(n_q0);
            r_dp[0].digits <= '0;
        end
        // Each digit stage peels the low decimal digit off
        for (int j = 1; j < NumDig; j++) begin
            if (d_ready[j]) begin
                r_dp[j] <= peel_digit(r_dp[j-1], 3'(j - 1));
            end
        end
        // Only the top digit is left in q here, its quotient is zero
        if (ser_free) begin
            r_ser <= peel_digit(r_dp[NumDig-1], 3'(NumDig - 1));
        end
        r_out_char <= n_char;
        r_out_last <= ser_done;
        r_out_err  <= r_ser.err;
    end

    // Byte select
    always_comb begin
        if (r_ser.err) begin
            n_char = CharErr;
        end else if (r_idx < 5'd12) begin
            if (!r_idx[0]) begin
                n_char = CharA + {5'b00000, r_idx[3:1]};
            end else begin
                n_char = CharZero + {4'b0000, r_ser.digits[3'd5 - r_idx[3:1]]};
            end
        end else begin
            case (r_idx)
                5'd12:   n_char = CharR;
                5'd13:   n_char = CharZero + {6'b000000, r_ser.rng};
                5'd14:   n_char = CharP;
                5'd15:   n_char = r_ser.neg ? CharTwo : CharOne;
                default: n_char = CharS;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_char_code    = r_out_char;
    assign o_last_char    = r_out_last;
    assign o_out_of_range = r_out_err;

endmodule

// ===== src/v2sc_checker.sv =====
module v2sc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic [7:0] o_char_code,
    input logic       o_last_char,
    input logic       o_out_of_range
);
    import v2sc_pkg::*;

    // Error result is a single zero byte that closes the transaction
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_last_char && (o_char_code == CharErr))
        else $error("error result malformed");

    // Bytes of one command come in consecutive cycles
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_char |=> o_valid)
        else $error("gap inside a command");

    // A command ends with 'S'
    a_last_s: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char && !o_out_of_range |-> (o_char_code == CharS))
        else $error("command does not end with S");

    // A new transaction opens with 'A' or is the error result
    a_first_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !($past(o_valid) && !$past(o_last_char))
        |-> (o_char_code == CharA) || o_out_of_range)
        else $error("command does not start with A");

endmodule

bind voltage_to_source_command v2sc_checker u_v2sc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .o_char_code    (o_char_code),
    .o_last_char    (o_last_char),
    .o_out_of_range (o_out_of_range)
);

// ===== tb/tb_voltage_to_source_command.sv =====
`timescale 1ns / 100ps

module tb_voltage_to_source_command;

    import v2sc_pkg::*;

    // Range limits of the encoding, in uV, and limits of the watchdog and error reports
    localparam logic [31:0] UvLimit    = 32'd1_000_000_000;
    localparam logic [31:0] Range3Base = 32'd100_000_000;
    localparam logic [31:0] Range2Base = 32'd10_000_000;
    localparam logic [31:0] Range1Base = 32'd1_000_000;
    localparam logic [31:0] FullScale  = 32'd1_000_000;
    localparam int          StallLimit = 5000;
    localparam int          MaxReports = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       oor;
    } t_cmd_char;

    // Round-half-up division of a magnitude by the step of a range
    function automatic logic [31:0] scale_to_range(logic [31:0] mag, logic [1:0] rng);
        logic [63:0] step;
        case (rng)
            Rng0:    step = 64'd1;
            Rng1:    step = 64'd10;
            Rng2:    step = 64'd100;
            default: step = 64'd1000;
        endcase
        return 32'(({32'd0, mag} + step / 2) / step);
    endfunction

    // Scoreboard: predicts the command bytes and checks them in order
    class cmd_scoreboard;
        t_cmd_char char_q[$];
        int        mismatches = 0;

        function void push_char(logic [7:0] code, logic last, logic oor);
            t_cmd_char c;
            c.code = code;
            c.last = last;
            c.oor  = oor;
            char_q.push_back(c);
        endfunction

        // Note an accepted voltage and queue its expected characters
        function void note_voltage(logic signed [30:0] v);
            logic [30:0] raw;
            logic        neg;
            logic [31:0] mag;
            logic [31:0] norm;
            logic [1:0]  rng;
            logic [3:0]  dig [6];
            raw  = v;
            neg  = raw[30];
            mag  = neg ? (32'h8000_0000 - {1'b0, raw}) : {1'b0, raw};
            if (mag >= UvLimit) begin
                push_char(CharErr, 1'b1, 1'b1);
                return;
            end
            if (mag >= Range3Base)      rng = Rng3;
            else if (mag >= Range2Base) rng = Rng2;
            else if (mag >= Range1Base) rng = Rng1;
            else                        rng = Rng0;
            norm = scale_to_range(mag, rng);
            // rounding carry pushes the value up one range
            while (norm >= FullScale) begin
                if (rng == Rng3) begin
                    push_char(CharErr, 1'b1, 1'b1);
                    return;
                end
                rng  = rng + 2'd1;
                norm = scale_to_range(mag, rng);
            end
            for (int i = 5; i >= 0; i--) begin
                dig[i] = 4'(norm % 10);
                norm   = norm / 10;
            end
            for (int i = 0; i < 6; i++) begin
                push_char(CharA + 8'(i), 1'b0, 1'b0);
                push_char(CharZero + 8'(dig[i]), 1'b0, 1'b0);
            end
            push_char(CharR, 1'b0, 1'b0);
            push_char(CharZero + 8'(rng), 1'b0, 1'b0);
            push_char(CharP, 1'b0, 1'b0);
            push_char(neg ? CharTwo : CharOne, 1'b0, 1'b0);
            push_char(CharS, 1'b1, 1'b0);
        endfunction

        // Compare one output character with the oldest expected one
        function void check_char(t_cmd_char got);
            t_cmd_char exp_c;
            if (char_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("unexpected char: code=%h last=%b oor=%b",
                             got.code, got.last, got.oor);
                return;
            end
            exp_c = char_q.pop_front();
            if (got !== exp_c) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display({"char mismatch: exp code=%h last=%b oor=%b, ",
                              "got code=%h last=%b oor=%b"},
                             exp_c.code, exp_c.last, exp_c.oor,
                             got.code, got.last, got.oor);
            end
        endfunction

        function int pending();
            return char_q.size();
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic signed [30:0] i_voltage_uv   = '0;
    logic               busy;
    logic               o_valid;
    logic [7:0]         o_char_code;
    logic               o_last_char;
    logic               o_out_of_range;

    cmd_scoreboard cmd_sb = new;
    int            stall_cycles = 0;

    voltage_to_source_command u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_voltage_uv   (i_voltage_uv),
        .o_valid        (o_valid),
        .o_char_code    (o_char_code),
        .o_last_char    (o_last_char),
        .o_out_of_range (o_out_of_range)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            cmd_sb.check_char({o_char_code, o_last_char, o_out_of_range});
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_rst_n && o_valid) || (i_rst_n && start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold start until the block takes the voltage
    task automatic send_voltage(input logic signed [30:0] v);
        start        <= 1'b1;
        i_voltage_uv <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cmd_sb.note_voltage(v);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            start        <= 1'b0;
            i_voltage_uv <= 31'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending until every queued character has come out
    task automatic drain_commands();
        start <= 1'b0;
        @(posedge i_clk);
        while (cmd_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mix of full-range, per-decade, near-boundary and tiny voltages
    function automatic logic signed [30:0] random_voltage();
        logic [31:0] mag;
        logic [31:0] lim;
        logic [31:0] edge_uv;
        int          sel;
        sel = $urandom_range(9);
        if (sel < 2) return 31'($urandom);
        if (sel < 6) begin
            lim = 32'd1;
            repeat ($urandom_range(9)) lim = lim * 10;
            mag = $urandom_range(lim, 0);
        end else if (sel < 8) begin
            case ($urandom_range(6))
                0:       edge_uv = 32'd1_000_000;
                1:       edge_uv = 32'd9_999_995;
                2:       edge_uv = 32'd10_000_000;
                3:       edge_uv = 32'd99_999_950;
                4:       edge_uv = 32'd100_000_000;
                5:       edge_uv = 32'd999_999_500;
                default: edge_uv = 32'd1_000_000_000;
            endcase
            mag = edge_uv + $urandom_range(200) - 100;
        end else begin
            mag = $urandom_range(2000);
        end
        if ($urandom_range(1)) return -$signed(31'(mag));
        return 31'(mag);
    endfunction

    // Sender idles in about idle_pct cycles of a hundred
    task automatic random_phase(input int n, input int idle_pct);
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99) < idle_pct) idle_gap(1);
            send_voltage(random_voltage());
        end
    endtask

    // Directed corner voltages
    logic signed [30:0] corner_uv [] = '{
        31'sd0, 31'sd1, -31'sd1, 31'sd999_999, -31'sd999_999,
        31'sd1_000_000, 31'sd9_999_994, 31'sd9_999_995, -31'sd9_999_995,
        31'sd10_000_000, 31'sd99_999_949, 31'sd99_999_950, 31'sd100_000_000,
        31'sd999_999_499, -31'sd999_999_499, 31'sd999_999_500, -31'sd999_999_500,
        31'sd1_000_000_000, -31'sd1_000_000_000, 31'sd1_073_741_823,
        -31'sd1_073_741_824, -31'sd1_073_741_823, 31'sd12_345_678, -31'sd5, 31'sd500
    };

    // Stimulus sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_uv[i]) send_voltage(corner_uv[i]);
        drain_commands();

        random_phase(170, 9);
        drain_commands();
        random_phase(170, 75);
        drain_commands();
        random_phase(160, 0);

        drain_commands();
        repeat (30) @(posedge i_clk);
        if (cmd_sb.mismatches == 0 && cmd_sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            if (cmd_sb.pending() != 0)
                $display("%0d expected chars never arrived", cmd_sb.pending());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== voltage_to_source_command.f =====
src/v2sc_pkg.sv
src/voltage_to_source_command.sv
src/v2sc_checker.sv
tb/tb_voltage_to_source_command.sv
